// ===== src/bpa_pkg.sv =====
// Shared types and constants for the buddy page allocator.
// Depends on nothing; bpa_stack_mem and buddy_page_allocator import it.
package bpa_pkg;

	localparam int ORDER_COUNT = 11;
	localparam int ORD_W       = 4;
	localparam int OFF_W       = ORDER_COUNT - 1;
	localparam int PAGES       = 1 << OFF_W;
	localparam int FILL_W      = OFF_W + 1;
	localparam int ADDR_W      = ORD_W + OFF_W;
	localparam int TOP         = ORDER_COUNT - 1;

	typedef enum logic [1:0] {
		ST_OK         = 2'd0,
		ST_ORDER_BIG  = 2'd1,
		ST_NO_BLOCK   = 2'd2,
		ST_BAD_OFFSET = 2'd3
	} status_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_POP,
		S_POP_WAIT,
		S_SPLIT,
		S_SPLIT_PUSH,
		S_CHECK,
		S_SRCH_RD,
		S_SRCH_CMP,
		S_SHF_RD,
		S_SHF_WR,
		S_PUSH,
		S_DONE
	} state_t;

	typedef struct packed {
		logic              we;
		logic [ADDR_W-1:0] waddr;
		logic [OFF_W-1:0]  wdata;
		logic              re;
		logic [ADDR_W-1:0] raddr;
	} mem_req_t;

endpackage

// ===== src/bpa_ifs.sv =====
// Request and response channel interfaces of the buddy page allocator.
// Standalone; widths are those of the request and response beats.
interface bpa_req_if;
	logic        valid;
	logic        ready;
	logic        command;
	logic [3:0]  order;
	logic [11:0] start_page;
	modport source(output valid, command, order, start_page, input ready);
	modport sink(input valid, command, order, start_page, output ready);
endinterface

interface bpa_rsp_if;
	logic        valid;
	logic        ready;
	logic [1:0]  status;
	logic [9:0]  block_offset;
	logic [10:0] free_pages;
	logic [10:0] used_pages;
	modport source(output valid, status, block_offset, free_pages, used_pages, input ready);
	modport sink(input valid, status, block_offset, free_pages, used_pages, output ready);
endinterface

// ===== src/bpa_stack_mem.sv =====
// Free-list storage: one synchronous RAM holding all per-order stacks.
// Depends on bpa_pkg; address is {order, stack index}, read data is registered.
module bpa_stack_mem (
	input  logic                     clk,
	input  bpa_pkg::mem_req_t        mreq,
	output logic [bpa_pkg::OFF_W-1:0] rd_data
);
	import bpa_pkg::*;

	logic [OFF_W-1:0] store_q [2**ADDR_W];

	always_ff @(posedge clk) begin
		if (mreq.we) begin
			store_q[mreq.waddr] <= mreq.wdata;
		end
		if (mreq.re) begin
			rd_data <= store_q[mreq.raddr];
		end
	end

endmodule

// ===== src/buddy_page_allocator.sv =====
// Buddy page allocator: per-order LIFO free lists in one simple dual-port RAM.
// One request at a time; the RAM's one read and one write per cycle set the pace.
// Reset clears the used total and every fill count but the top order's, which it
// sets to one, and sets the free total to all pages, at once; the RAM is not cleared,
// and the top-order stack is read as offset 0, the only block that order can hold.
module buddy_page_allocator (
	input logic       clk,
	input logic       arst_n,
	bpa_req_if.sink   req,
	bpa_rsp_if.source rsp
);
	import bpa_pkg::*;

	state_t            state_q, state_d;
	logic [ORD_W-1:0]  ord_q, cur_q;
	logic [OFF_W-1:0]  off_q, blk_q, res_q;
	logic [FILL_W-1:0] idx_q;
	status_t           status_q;
	logic              top_rd_q;
	logic [FILL_W-1:0] fill_q [ORDER_COUNT];
	logic [FILL_W-1:0] free_q, used_q;

	logic              ov_q;
	status_t           out_status_q;
	logic [OFF_W-1:0]  out_off_q;
	logic [FILL_W-1:0] out_free_q, out_used_q;

	mem_req_t          mreq;
	logic [OFF_W-1:0]  rd_data;

	bpa_stack_mem u_mem (
		.clk    (clk),
		.mreq   (mreq),
		.rd_data(rd_data)
	);

	// request decode
	logic              acc, too_big, bad_off, hit, fire, match, cur_full;
	logic [ORD_W-1:0]  found;
	logic [15:0]       mask;
	logic [FILL_W-1:0] size, cur_fill;
	logic [OFF_W-1:0]  bsz, buddy;
	logic [FILL_W:0]   used_add, free_add;
	logic [FILL_W-1:0] used_inc, used_dec, free_inc, free_dec;

	assign acc      = req.valid && req.ready;
	assign too_big  = {1'b0, req.order} >= 5'(ORDER_COUNT);
	assign mask     = (16'(1) << req.order) - 16'(1);
	assign bad_off  = (17'(req.start_page) >= 17'(PAGES)) ||
	                  ((16'(req.start_page) & mask) != 16'(0));
	assign size     = FILL_W'(1) << req.order;
	assign cur_fill = fill_q[cur_q];
	assign cur_full = cur_fill >= FILL_W'(PAGES);
	assign bsz      = OFF_W'(1) << cur_q;
	assign buddy    = off_q ^ bsz;
	assign match    = rd_data == buddy;
	assign fire     = !ov_q || rsp.ready;

	// saturating page totals
	assign used_add = (FILL_W+1)'(used_q) + (FILL_W+1)'(size);
	assign free_add = (FILL_W+1)'(free_q) + (FILL_W+1)'(size);
	assign used_inc = (used_add > (FILL_W+1)'(PAGES)) ? FILL_W'(PAGES) : used_add[FILL_W-1:0];
	assign free_inc = (free_add > (FILL_W+1)'(PAGES)) ? FILL_W'(PAGES) : free_add[FILL_W-1:0];
	assign used_dec = (size > used_q) ? '0 : used_q - size;
	assign free_dec = (size > free_q) ? '0 : free_q - size;

	// lowest non-empty order at or above the requested one
	always_comb begin
		hit   = 1'b0;
		found = '0;
		for (int k = 0; k < ORDER_COUNT; k++) begin
			if (!hit && fill_q[k] != '0 && ORD_W'(k) >= req.order) begin
				hit   = 1'b1;
				found = ORD_W'(k);
			end
		end
	end

	assign req.ready = state_q == S_IDLE;

	// next state and RAM strobes
	always_comb begin
		state_d = state_q;
		mreq    = '0;
		unique case (state_q)
			S_IDLE: begin
				if (acc) begin
					if (too_big) state_d = S_DONE;
					else if (!req.command) state_d = hit ? S_POP : S_DONE;
					else state_d = bad_off ? S_DONE : S_CHECK;
				end
			end
			S_POP: begin
				mreq.re    = 1'b1;
				mreq.raddr = {cur_q, OFF_W'(cur_fill - FILL_W'(1))};
				state_d    = S_POP_WAIT;
			end
			S_POP_WAIT: state_d = S_SPLIT;
			S_SPLIT: state_d = (cur_q > ord_q) ? S_SPLIT_PUSH : S_DONE;
			S_SPLIT_PUSH: begin
				// push the upper half onto its order's stack
				mreq.we    = !cur_full;
				mreq.waddr = {cur_q, cur_fill[OFF_W-1:0]};
				mreq.wdata = blk_q + bsz;
				state_d    = S_SPLIT;
			end
			S_CHECK: begin
				state_d = (cur_q < ORD_W'(TOP) && cur_fill != '0) ? S_SRCH_RD : S_PUSH;
			end
			S_SRCH_RD: begin
				mreq.re    = 1'b1;
				mreq.raddr = {cur_q, idx_q[OFF_W-1:0]};
				state_d    = S_SRCH_CMP;
			end
			S_SRCH_CMP: begin
				if (match) state_d = S_SHF_RD;
				else state_d = (idx_q == '0) ? S_PUSH : S_SRCH_RD;
			end
			S_SHF_RD: begin
				if (idx_q < cur_fill) begin
					mreq.re    = 1'b1;
					mreq.raddr = {cur_q, idx_q[OFF_W-1:0]};
					state_d    = S_SHF_WR;
				end else begin
					state_d = S_CHECK;
				end
			end
			S_SHF_WR: begin
				// close the gap left by the merged buddy
				mreq.we    = 1'b1;
				mreq.waddr = {cur_q, OFF_W'(idx_q - FILL_W'(1))};
				mreq.wdata = rd_data;
				state_d    = S_SHF_RD;
			end
			S_PUSH: begin
				// the top order only ever holds offset 0, which reads return directly
				mreq.we    = !cur_full && cur_q != ORD_W'(TOP);
				mreq.waddr = {cur_q, cur_fill[OFF_W-1:0]};
				mreq.wdata = off_q;
				state_d    = S_DONE;
			end
			S_DONE: if (fire) state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// fill counts, page totals, response valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < ORDER_COUNT; k++) begin
				fill_q[k] <= (k == TOP) ? FILL_W'(1) : '0;
			end
			free_q <= FILL_W'(PAGES);
			used_q <= '0;
			ov_q   <= 1'b0;
		end else begin
			// raise on a finished request, drop once the beat is taken
			if (state_q == S_DONE && fire) ov_q <= 1'b1;
			else if (ov_q && rsp.ready) ov_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (acc && !too_big) begin
						if (!req.command && hit) begin
							used_q <= used_inc;
							free_q <= free_dec;
						end else if (req.command && !bad_off) begin
							used_q <= used_dec;
							free_q <= free_inc;
						end
					end
				end
				S_POP: fill_q[cur_q] <= cur_fill - FILL_W'(1);
				S_SPLIT_PUSH, S_PUSH: if (!cur_full) fill_q[cur_q] <= cur_fill + FILL_W'(1);
				S_SHF_RD: if (idx_q >= cur_fill) fill_q[cur_q] <= cur_fill - FILL_W'(1);
				default: ;
			endcase
		end
	end

	// working and response payload
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (acc) begin
					ord_q <= req.order;
					off_q <= req.start_page[OFF_W-1:0];
					res_q <= '0;
					cur_q <= req.command ? req.order : found;
					if (too_big) status_q <= ST_ORDER_BIG;
					else if (!req.command) status_q <= hit ? ST_OK : ST_NO_BLOCK;
					else status_q <= bad_off ? ST_BAD_OFFSET : ST_OK;
				end
			end
			S_POP: top_rd_q <= cur_q == ORD_W'(TOP);
			S_POP_WAIT: begin
				blk_q <= top_rd_q ? '0 : rd_data;
				res_q <= top_rd_q ? '0 : rd_data;
			end
			S_SPLIT: if (cur_q > ord_q) cur_q <= cur_q - ORD_W'(1);
			S_CHECK: idx_q <= cur_fill - FILL_W'(1);
			S_SRCH_CMP: begin
				if (match) idx_q <= idx_q + FILL_W'(1);
				else if (idx_q != '0) idx_q <= idx_q - FILL_W'(1);
			end
			S_SHF_RD: begin
				if (idx_q >= cur_fill) begin
					// buddy gone: advance to the merged block one order up
					off_q <= off_q & ~bsz;
					cur_q <= cur_q + ORD_W'(1);
				end
			end
			S_SHF_WR: idx_q <= idx_q + FILL_W'(1);
			S_DONE: begin
				if (fire) begin
					out_status_q <= status_q;
					out_off_q    <= res_q;
					out_free_q   <= free_q;
					out_used_q   <= used_q;
				end
			end
			default: ;
		endcase
	end

	assign rsp.valid        = ov_q;
	assign rsp.status       = out_status_q;
	assign rsp.block_offset = 10'(out_off_q);
	assign rsp.free_pages   = 11'(out_free_q);
	assign rsp.used_pages   = 11'(out_used_q);

	a_no_top_write: assert property (@(posedge clk) disable iff (!arst_n)
		mreq.we |-> mreq.waddr[ADDR_W-1:OFF_W] != ORD_W'(TOP))
		else $error("write into top-order stack");

	a_fail_zero_offset: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && rsp.status != 2'(ST_OK) |-> rsp.block_offset == '0)
		else $error("failed request carries an offset");

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		req.valid && req.ready |=> state_q != S_IDLE)
		else $error("accepted beat not processed");

	a_shift_index: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_SHF_WR |-> idx_q != '0 && $past(state_q) == S_SHF_RD)
		else $error("compaction index underflow");

endmodule
